>>> rtl/escape_sequence_decoder_unit_defines.svh
// Assertion macros shared by the decoder modules.
`ifndef ESCAPE_SEQUENCE_DECODER_UNIT_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define ESD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ESD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ESD_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ESD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/esd_pkg.sv
package esd_pkg;

    localparam int unsigned FIFO_DEPTH_DEF = 4;

    localparam logic [1:0] REG_OUTPUT_HEX     = 2'd0;
    localparam logic [1:0] REG_INSERT_SPACE   = 2'd1;
    localparam logic [1:0] REG_DECODE_ESCAPES = 2'd2;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_UP_A      = 8'h41;
    localparam logic [7:0] CH_UP_F      = 8'h46;
    localparam logic [7:0] CH_LO_A      = 8'h61;
    localparam logic [7:0] CH_LO_F      = 8'h66;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [3:0] NIB_TEN      = 4'h0a;
    localparam logic [3:0] NIB_HEX_ADJ  = 4'd9;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_BS   = 6'b000010,
        PH_X    = 6'b000100,
        PH_H1   = 6'b001000,
        PH_O1   = 6'b010000,
        PH_O2   = 6'b100000
    } esd_phase_t;

    typedef struct packed {
        logic output_hex;
        logic insert_space;
        logic decode_escapes;
    } esd_cfg_t;

    typedef struct packed {
        logic [7:0] b1;
        logic [7:0] b0;
        logic [1:0] nbytes;
        logic       last;
    } esd_entry_t;

    // {valid, digit value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F)) begin
            r = {1'b1, 4'(c[3:0] + NIB_HEX_ADJ)};
        end
        return r;
    endfunction

    // {valid, byte}
    function automatic logic [8:0] named_escape(input logic [7:0] c);
        logic [8:0] r;
        r = '0;
        case (c)
            8'h61: r = {1'b1, 8'h07};
            8'h62: r = {1'b1, 8'h08};
            8'h66: r = {1'b1, 8'h0c};
            8'h6e: r = {1'b1, 8'h0a};
            8'h72: r = {1'b1, 8'h0d};
            8'h74: r = {1'b1, 8'h09};
            8'h76: r = {1'b1, 8'h0b};
            8'h5c: r = {1'b1, 8'h5c};
            8'h27: r = {1'b1, 8'h27};
            8'h22: r = {1'b1, 8'h22};
            8'h3f: r = {1'b1, 8'h3f};
            8'h00: r = {1'b1, 8'h00};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < NIB_TEN) begin
            r = CH_ZERO + {4'd0, nib};
        end else begin
            r = CH_UP_A + {4'd0, 4'(nib - NIB_TEN)};
        end
        return r;
    endfunction

endpackage

>>> rtl/escape_sequence_decoder_unit.sv
// Streaming C escape decoder. Each input word carries one source byte; the front
// decodes escapes and queues up to two decoded bytes per word, and the back turns
// each decoded byte into one output word (raw), two (hex) or three (hex with space).
// An input word is taken every cycle while the queue has room; the single output
// register emits one character per cycle while the sink is ready and an entry is
// queued, so the output words that each input word yields bound the input rate.
// Configure only while idle.
module escape_sequence_decoder_unit import esd_pkg::*; #(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] out_byte, [8] run_last, [15:9] zero
    output logic        m_tuser,    // byte_valid
    output logic        m_tlast,    // string_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    esd_cfg_t   cfg_reg;
    logic       cfg_wr;
    logic       push, pop, full, empty;
    esd_entry_t push_entry, head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.output_hex     <= 1'b0;
            cfg_reg.insert_space   <= 1'b0;
            cfg_reg.decode_escapes <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_OUTPUT_HEX:     cfg_reg.output_hex     <= pwdata[0];
                REG_INSERT_SPACE:   cfg_reg.insert_space   <= pwdata[0];
                REG_DECODE_ESCAPES: cfg_reg.decode_escapes <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_OUTPUT_HEX:     prdata = {31'd0, cfg_reg.output_hex};
            REG_INSERT_SPACE:   prdata = {31'd0, cfg_reg.insert_space};
            REG_DECODE_ESCAPES: prdata = {31'd0, cfg_reg.decode_escapes};
            default:            prdata = 32'd0;
        endcase
    end

    esd_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .decode_escapes (cfg_reg.decode_escapes),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .fifo_full      (full),
        .push           (push),
        .push_entry     (push_entry)
    );

    esd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    esd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> rtl/esd_front.sv
`include "escape_sequence_decoder_unit_defines.svh"

module esd_front import esd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       decode_escapes,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] in_byte
    input  logic       s_tlast,     // in_last
    input  logic       fifo_full,
    output logic       push,
    output esd_entry_t push_entry
);

    esd_phase_t phase_reg, phase_next;
    logic [7:0] value_reg, value_next;

    logic       accept;
    logic       a_v, c_v, l_v;
    logic [7:0] a_b, c_b, l_b, c;
    logic [4:0] hd;
    logic [8:0] ne;
    logic       is_oct;

    assign c      = s_tdata;
    assign hd     = hex_digit(c);
    assign ne     = named_escape(c);
    assign is_oct = (c >= CH_ZERO) && (c <= CH_SEVEN);

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        phase_next = phase_reg;
        value_next = value_reg;
        a_v = 1'b0;
        a_b = value_reg;
        c_v = 1'b0;
        c_b = c;
        l_v = 1'b0;
        l_b = 8'd0;
        if (!decode_escapes) begin
            a_v = (phase_reg == PH_X) || (phase_reg == PH_H1) ||
                  (phase_reg == PH_O1) || (phase_reg == PH_O2);
            a_b = (phase_reg == PH_X) ? CH_X : value_reg;
            phase_next = PH_IDLE;
            value_next = 8'd0;
            c_v = 1'b1;
        end else begin
            unique case (phase_reg) inside
                PH_BS: begin
                    if (ne[8]) begin
                        c_v = 1'b1;
                        c_b = ne[7:0];
                        phase_next = PH_IDLE;
                    end else if (c == CH_X) begin
                        phase_next = PH_X;
                    end else if (is_oct) begin
                        value_next = {5'd0, c[2:0]};
                        phase_next = PH_O1;
                    end else begin
                        phase_next = PH_IDLE;
                        c_v = 1'b1;
                    end
                end
                PH_X, PH_H1: begin
                    if (hd[4] && phase_reg == PH_X) begin
                        value_next = {4'd0, hd[3:0]};
                        phase_next = PH_H1;
                    end else if (hd[4]) begin
                        c_v = 1'b1;
                        c_b = {value_reg[3:0], hd[3:0]};
                        phase_next = PH_IDLE;
                        value_next = 8'd0;
                    end else begin
                        a_v = 1'b1;
                        a_b = (phase_reg == PH_X) ? CH_X : value_reg;
                        value_next = 8'd0;
                        if (c == CH_BACKSLASH) begin
                            phase_next = PH_BS;
                        end else begin
                            phase_next = PH_IDLE;
                            c_v = 1'b1;
                        end
                    end
                end
                PH_O1, PH_O2: begin
                    if (is_oct && phase_reg == PH_O1) begin
                        value_next = {value_reg[4:0], c[2:0]};
                        phase_next = PH_O2;
                    end else if (is_oct) begin
                        c_v = 1'b1;
                        c_b = {value_reg[4:0], c[2:0]};
                        phase_next = PH_IDLE;
                        value_next = 8'd0;
                    end else begin
                        a_v = 1'b1;
                        a_b = value_reg;
                        value_next = 8'd0;
                        if (c == CH_BACKSLASH) begin
                            phase_next = PH_BS;
                        end else begin
                            phase_next = PH_IDLE;
                            c_v = 1'b1;
                        end
                    end
                end
                default: begin
                    if (c == CH_BACKSLASH) begin
                        phase_next = PH_BS;
                    end else begin
                        phase_next = PH_IDLE;
                        c_v = 1'b1;
                    end
                end
            endcase
        end
        if (s_tlast) begin
            l_v = (phase_next == PH_X) || (phase_next == PH_H1) ||
                  (phase_next == PH_O1) || (phase_next == PH_O2);
            l_b = (phase_next == PH_X) ? CH_X : value_next;
            phase_next = PH_IDLE;
            value_next = 8'd0;
        end
    end

    always_comb begin
        push_entry.last   = s_tlast;
        push_entry.nbytes = 2'({1'b0, a_v} + {1'b0, c_v} + {1'b0, l_v});
        push_entry.b0     = a_v ? a_b : (c_v ? c_b : l_b);
        push_entry.b1     = (a_v && c_v) ? c_b : l_b;
    end

    assign push = accept && ((push_entry.nbytes != 2'd0) || s_tlast);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            value_reg <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            value_reg <= value_next;
        end
    end

    `ESD_ASSERT_NEXT(a_last_closes, aclk, aresetn, accept && s_tlast, phase_reg == PH_IDLE)
    `ESD_ASSERT_IMPL(a_hex_value_narrow, aclk, aresetn, phase_reg == PH_H1, value_reg[7:4] == 4'd0)

endmodule

>>> rtl/esd_fifo.sv
`include "escape_sequence_decoder_unit_defines.svh"

module esd_fifo import esd_pkg::*; #(
    parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  esd_entry_t push_entry,
    input  logic       pop,
    output esd_entry_t head,
    output logic       full,
    output logic       empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    esd_entry_t         mem_reg [DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_entry;
        end
    end

    `ESD_ASSERT_IMPL(a_no_overflow, aclk, aresetn, push, !full)
    `ESD_ASSERT_IMPL(a_no_underflow, aclk, aresetn, pop, !empty)

endmodule

>>> rtl/esd_back.sv
`include "escape_sequence_decoder_unit_defines.svh"

module esd_back import esd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  esd_cfg_t    cfg,
    input  esd_entry_t  head,
    input  logic        empty,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] out_byte, [8] run_last, [15:9] zero
    output logic        m_tuser,    // byte_valid
    output logic        m_tlast     // string_end
);

    logic       busy_reg, busy_next;
    esd_entry_t ent_reg;
    logic       bsel_reg;
    logic [1:0] sub_reg;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] obyte_reg;
    logic       bvalid_reg, rlast_reg, send_reg;

    logic       load, sub_final, final_char, cur_valid;
    logic [7:0] cur_byte, cur_char;

    assign cur_byte   = bsel_reg ? ent_reg.b1 : ent_reg.b0;
    assign sub_final  = !cfg.output_hex || (sub_reg == 2'd1 && !cfg.insert_space) ||
                        (sub_reg == 2'd2);
    assign final_char = (ent_reg.nbytes == 2'd0) ||
                        (sub_final && (bsel_reg || ent_reg.nbytes != 2'd2));
    assign load       = busy_reg && (!m_valid_reg || m_tready);
    assign pop        = !empty && (!busy_reg || (load && final_char));

    always_comb begin
        cur_valid = 1'b1;
        if (ent_reg.nbytes == 2'd0) begin
            cur_char  = 8'd0;
            cur_valid = 1'b0;
        end else if (!cfg.output_hex) begin
            cur_char = cur_byte;
        end else begin
            case (sub_reg)
                2'd0:    cur_char = hex_char(cur_byte[7:4]);
                2'd1:    cur_char = hex_char(cur_byte[3:0]);
                default: cur_char = CH_SPACE;
            endcase
        end
    end

    always_comb begin
        busy_next = busy_reg;
        if (pop) begin
            busy_next = 1'b1;
        end else if (load && final_char) begin
            busy_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            ent_reg  <= head;
            bsel_reg <= 1'b0;
            sub_reg  <= 2'd0;
        end else if (load) begin
            if (sub_final) begin
                sub_reg  <= 2'd0;
                bsel_reg <= 1'b1;
            end else begin
                sub_reg <= sub_reg + 2'd1;
            end
        end
        if (load) begin
            obyte_reg  <= cur_char;
            bvalid_reg <= cur_valid;
            rlast_reg  <= final_char;
            send_reg   <= final_char && ent_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, rlast_reg, obyte_reg};
    assign m_tuser  = bvalid_reg;
    assign m_tlast  = send_reg;

    `ESD_ASSERT_IMPL(a_end_is_run_last, aclk, aresetn, m_valid_reg && send_reg, rlast_reg)
    `ESD_ASSERT_IMPL(a_empty_entry_is_last, aclk, aresetn,
                     busy_reg && ent_reg.nbytes == 2'd0, ent_reg.last)

endmodule
